[hdl/ccq_pkg.sv]
`default_nettype none

package ccq_pkg;

    // defaults for the top-level parameters
    localparam int CLASS_DEPTH_DEF  = 64;
    localparam int PHONE_DIGITS_DEF = 10;

    // fixed field widths
    localparam int REQ_W    = 2;
    localparam int CLASS_W  = 2;
    localparam int PHONE_W  = 34;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 7;
    localparam int TOTAL_W  = 8;

    // request codes
    localparam logic [REQ_W-1:0] REQ_INSERT  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_SERVE   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_DISMISS = 2'd2;
    localparam logic [REQ_W-1:0] REQ_NOP     = 2'd3;

    // class codes
    localparam logic [CLASS_W-1:0] CLASS_NONE      = 2'd0;
    localparam logic [CLASS_W-1:0] CLASS_DATA      = 2'd1;
    localparam logic [CLASS_W-1:0] CLASS_VOICE     = 2'd2;
    localparam logic [CLASS_W-1:0] CLASS_EMERGENCY = 2'd3;

    // status codes
    localparam logic [STATUS_W-1:0] STATUS_DONE       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY      = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL       = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_NO_DISMISS = 2'd3;

    // decoded operation handed from front to back
    typedef enum logic [2:0] {
        OP_INSERT  = 3'd0,
        OP_REJECT  = 3'd1,
        OP_SERVE   = 3'd2,
        OP_DISMISS = 3'd3,
        OP_NOP     = 3'd4
    } op_t;

    typedef struct packed {
        logic [REQ_W-1:0]   req_type;
        logic [CLASS_W-1:0] call_class;
        logic [PHONE_W-1:0] phone_value;
    } call_req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [PHONE_W-1:0]  served_phone;
        logic [CLASS_W-1:0]  served_class;
        logic [COUNT_W-1:0]  count_data;
        logic [COUNT_W-1:0]  count_voice;
        logic [COUNT_W-1:0]  count_emergency;
        logic [TOTAL_W-1:0]  total_waiting;
        logic                all_empty;
    } call_res_t;

    typedef struct packed {
        op_t                op;
        logic [CLASS_W-1:0] cls_idx;
        logic [PHONE_W-1:0] phone;
    } cmd_t;

    // largest value with the given number of decimal digits
    function automatic logic [63:0] phone_limit(input int digits);
        logic [63:0] lim;
        lim = 64'd1;
        for (int d = 0; d < digits; d++)
        begin
            lim = lim * 64'd10;
        end
        return lim - 64'd1;
    endfunction

endpackage

`default_nettype wire

[hdl/three_class_priority_call_queue_core.sv]
`default_nettype none

// channel   | handshake            | payload
// ----------+----------------------+------------------------------------
// request   | push / full          | req : call_req_t (type, class, phone)
// result    | pop / empty          | res : call_res_t (status, call, counts)
//
// a request transfer lands in a two-entry command queue in the front part,
// where it is decoded and its number saturated to the digit limit
// the back part executes one command a cycle while the result queue has room
// for it and for the result still in flight; the entry store read is
// registered beside the execute stage, so a result passes the command
// queue, the execute stage and the result queue before the result ports;
// a command is held while one result is queued and another is in flight
// reset clears the class pointers, counts and both queues; the entry store
// is not cleared and needs no clearing pass
// a stalled result side fills the result queue, then the command queue,
// then raises full
module three_class_priority_call_queue_core #(
    parameter int CLASS_DEPTH  = ccq_pkg::CLASS_DEPTH_DEF,
    parameter int PHONE_DIGITS = ccq_pkg::PHONE_DIGITS_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    output logic                    full,
    input  wire ccq_pkg::call_req_t req,
    output logic                    empty,
    input  wire logic               pop,
    output ccq_pkg::call_res_t      res
);

    // decoded command between the two parts
    logic          cmd_valid;
    logic          cmd_take;
    ccq_pkg::cmd_t cmd;

    // front: accepts, classifies and saturates
    ccq_front #(
        .PHONE_DIGITS (PHONE_DIGITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .req       (req),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_take  (cmd_take)
    );

    // back: class rings, entry store and result queue
    ccq_back #(
        .CLASS_DEPTH (CLASS_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_take  (cmd_take),
        .empty     (empty),
        .pop       (pop),
        .res       (res)
    );

endmodule

`default_nettype wire

[hdl/ccq_front.sv]
`default_nettype none

module ccq_front #(
    parameter int PHONE_DIGITS = ccq_pkg::PHONE_DIGITS_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    output logic                   full,
    input  wire ccq_pkg::call_req_t req,
    output logic                   cmd_valid,
    output ccq_pkg::cmd_t          cmd,
    input  wire logic              cmd_take
);

    localparam logic [63:0] LIMIT = ccq_pkg::phone_limit(PHONE_DIGITS);

    ccq_pkg::cmd_t cmd_new;
    ccq_pkg::cmd_t q_reg [2];
    logic          wr_ptr_reg, wr_ptr_next;
    logic          rd_ptr_reg, rd_ptr_next;
    logic [1:0]    cnt_reg, cnt_next;
    logic          do_push;
    logic          do_pop;

    // classify and saturate
    always_comb
    begin
        cmd_new.cls_idx = req.call_class - 2'd1;
        if ({30'd0, req.phone_value} > LIMIT)
        begin
            cmd_new.phone = LIMIT[ccq_pkg::PHONE_W-1:0];
        end
        else
        begin
            cmd_new.phone = req.phone_value;
        end
        unique case (req.req_type)
            ccq_pkg::REQ_INSERT:
            begin
                if (req.call_class == ccq_pkg::CLASS_NONE)
                begin
                    cmd_new.op = ccq_pkg::OP_REJECT;
                end
                else
                begin
                    cmd_new.op = ccq_pkg::OP_INSERT;
                end
            end
            ccq_pkg::REQ_SERVE:   cmd_new.op = ccq_pkg::OP_SERVE;
            ccq_pkg::REQ_DISMISS: cmd_new.op = ccq_pkg::OP_DISMISS;
            ccq_pkg::REQ_NOP:     cmd_new.op = ccq_pkg::OP_NOP;
            default:              cmd_new.op = ccq_pkg::OP_NOP;
        endcase
    end

    assign full      = (cnt_reg == 2'd2);
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = q_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = cmd_take && cmd_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        cnt_next    = cnt_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_reg[wr_ptr_reg] <= cmd_new;
        end
    end

endmodule

`default_nettype wire

[hdl/ccq_back.sv]
`default_nettype none

module ccq_back #(
    parameter int CLASS_DEPTH = ccq_pkg::CLASS_DEPTH_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cmd_valid,
    input  wire ccq_pkg::cmd_t     cmd,
    output logic                   cmd_take,
    output logic                   empty,
    input  wire logic              pop,
    output ccq_pkg::call_res_t     res
);

    localparam int PW = $clog2(CLASS_DEPTH);
    localparam int CW = $clog2(CLASS_DEPTH + 1);
    localparam int TW = CW + 2;
    localparam int SD = 3 * CLASS_DEPTH;
    localparam int AW = $clog2(SD);

    // class pointers and counts
    logic [PW-1:0] head_reg [3];
    logic [PW-1:0] head_next [3];
    logic [PW-1:0] tail_reg [3];
    logic [PW-1:0] tail_next [3];
    logic [CW-1:0] cnt_reg [3];
    logic [CW-1:0] cnt_next [3];

    // entry store
    logic [ccq_pkg::PHONE_W-1:0] mem [SD];
    logic [ccq_pkg::PHONE_W-1:0] rd_reg;
    logic                        mem_we;
    logic                        mem_re;
    logic [AW-1:0]               mem_addr;
    logic [1:0]                  sel;
    logic [PW-1:0]               sel_ptr;

    // execute stage
    logic                         exec;
    logic [ccq_pkg::STATUS_W-1:0] status;
    logic [ccq_pkg::CLASS_W-1:0]  srv_class;
    logic                         srv_hit;
    logic [TW-1:0]                total;
    ccq_pkg::call_res_t           s1_res_next;
    ccq_pkg::call_res_t           s1_res_reg;
    logic                         s1_valid_reg;
    logic                         s1_serve_reg;

    // result queue
    ccq_pkg::call_res_t rq_reg [2];
    ccq_pkg::call_res_t rq_in;
    logic               rq_wr_reg;
    logic               rq_rd_reg;
    logic [1:0]         rq_cnt_reg, rq_cnt_next;
    logic               rq_pop;

    function automatic logic [PW-1:0] ring_next(input logic [PW-1:0] pos);
        if (pos == PW'(CLASS_DEPTH - 1))
        begin
            return '0;
        end
        return pos + PW'(1);
    endfunction

    // room for this result and the one in flight
    assign exec     = cmd_valid &&
                      (({1'b0, rq_cnt_reg} + {2'b0, s1_valid_reg}) < 3'd2);
    assign cmd_take = exec;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            head_next[i] = head_reg[i];
            tail_next[i] = tail_reg[i];
            cnt_next[i]  = cnt_reg[i];
        end
        status    = ccq_pkg::STATUS_DONE;
        srv_class = ccq_pkg::CLASS_NONE;
        srv_hit   = 1'b0;
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        sel       = cmd.cls_idx;
        sel_ptr   = tail_reg[cmd.cls_idx];
        if (exec)
        begin
            unique case (cmd.op)
                ccq_pkg::OP_INSERT:
                begin
                    if (cnt_reg[sel] == CW'(CLASS_DEPTH))
                    begin
                        status = ccq_pkg::STATUS_FULL;
                    end
                    else
                    begin
                        mem_we         = 1'b1;
                        tail_next[sel] = ring_next(tail_reg[sel]);
                        cnt_next[sel]  = cnt_reg[sel] + CW'(1);
                    end
                end
                ccq_pkg::OP_REJECT:
                begin
                    status = ccq_pkg::STATUS_FULL;
                end
                ccq_pkg::OP_SERVE:
                begin
                    // highest non-empty class wins
                    priority if (cnt_reg[2] != '0)
                    begin
                        sel = 2'd2;
                    end
                    else if (cnt_reg[1] != '0)
                    begin
                        sel = 2'd1;
                    end
                    else
                    begin
                        sel = 2'd0;
                    end
                    sel_ptr = head_reg[sel];
                    if (cnt_reg[sel] == '0)
                    begin
                        status = ccq_pkg::STATUS_EMPTY;
                    end
                    else
                    begin
                        mem_re         = 1'b1;
                        srv_hit        = 1'b1;
                        srv_class      = sel + 2'd1;
                        head_next[sel] = ring_next(head_reg[sel]);
                        cnt_next[sel]  = cnt_reg[sel] - CW'(1);
                    end
                end
                ccq_pkg::OP_DISMISS:
                begin
                    // lowest non-empty class, emergency never
                    priority if (cnt_reg[0] != '0)
                    begin
                        head_next[0] = tail_reg[0];
                        cnt_next[0]  = '0;
                    end
                    else if (cnt_reg[1] != '0)
                    begin
                        head_next[1] = tail_reg[1];
                        cnt_next[1]  = '0;
                    end
                    else
                    begin
                        status = ccq_pkg::STATUS_NO_DISMISS;
                    end
                end
                ccq_pkg::OP_NOP:
                begin
                    status = ccq_pkg::STATUS_DONE;
                end
                default:
                begin
                    status = ccq_pkg::STATUS_DONE;
                end
            endcase
        end
        mem_addr = AW'(sel) * AW'(CLASS_DEPTH) + AW'(sel_ptr);
    end

    always_comb
    begin
        total = TW'(cnt_next[0]) + TW'(cnt_next[1]) + TW'(cnt_next[2]);
        s1_res_next.status          = status;
        s1_res_next.served_phone    = '0;
        s1_res_next.served_class    = srv_class;
        s1_res_next.count_data      = ccq_pkg::COUNT_W'(cnt_next[0]);
        s1_res_next.count_voice     = ccq_pkg::COUNT_W'(cnt_next[1]);
        s1_res_next.count_emergency = ccq_pkg::COUNT_W'(cnt_next[2]);
        s1_res_next.total_waiting   = ccq_pkg::TOTAL_W'(total);
        s1_res_next.all_empty       = (total == '0);
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= cmd.phone;
        end
        if (mem_re)
        begin
            rd_reg <= mem[mem_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                head_reg[i] <= '0;
                tail_reg[i] <= '0;
                cnt_reg[i]  <= '0;
            end
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            for (int i = 0; i < 3; i++)
            begin
                head_reg[i] <= head_next[i];
                tail_reg[i] <= tail_next[i];
                cnt_reg[i]  <= cnt_next[i];
            end
            s1_valid_reg <= exec;
        end
    end

    always_ff @(posedge clk)
    begin
        if (exec)
        begin
            s1_res_reg   <= s1_res_next;
            s1_serve_reg <= srv_hit;
        end
    end

    // merge the read data into the result
    always_comb
    begin
        rq_in = s1_res_reg;
        if (s1_serve_reg)
        begin
            rq_in.served_phone = rd_reg;
        end
    end

    assign empty       = (rq_cnt_reg == 2'd0);
    assign res         = rq_reg[rq_rd_reg];
    assign rq_pop      = pop && !empty;
    assign rq_cnt_next = rq_cnt_reg + {1'b0, s1_valid_reg} - {1'b0, rq_pop};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rq_wr_reg  <= 1'b0;
            rq_rd_reg  <= 1'b0;
            rq_cnt_reg <= 2'd0;
        end
        else
        begin
            rq_wr_reg  <= rq_wr_reg ^ s1_valid_reg;
            rq_rd_reg  <= rq_rd_reg ^ rq_pop;
            rq_cnt_reg <= rq_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            rq_reg[rq_wr_reg] <= rq_in;
        end
    end

endmodule

`default_nettype wire
